// ----- design/ica_pkg.sv -----
// Shared types and codes for the integer calculator ALU.
package ica_pkg;

   localparam int KIND_W   = 4;
   localparam int RESULT_W = 64;
   localparam int STATUS_W = 2;

   // operation codes
   typedef enum logic [KIND_W-1:0] {
      K_ADD  = 4'd0,
      K_SUB  = 4'd1,
      K_MUL  = 4'd2,
      K_RDIV = 4'd3,
      K_IDIV = 4'd4,
      K_REM  = 4'd5,
      K_FACT = 4'd6,
      K_POW  = 4'd7,
      K_SQRT = 4'd8
   } kind_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STS_OK        = 2'd0,
      STS_DIV_ZERO  = 2'd1,
      STS_NEG_OPND  = 2'd2,
      STS_SATURATED = 2'd3
   } status_type;

   // how the final result is formed
   typedef enum logic [2:0] {
      FIN_ZERO,
      FIN_INT,
      FIN_SCALED,
      FIN_SAT,
      FIN_DIV0,
      FIN_NEG
   } fin_type;

   // multiplier second operand
   typedef enum logic [1:0] {
      Y_MB,
      Y_MA,
      Y_CNT
   } ysel_type;

   // divider dividend
   typedef enum logic [1:0] {
      DVD_MA,
      DVD_MA_SCALED,
      DVD_ONE
   } dvd_type;

   // divider divisor
   typedef enum logic {
      DVS_MB,
      DVS_MAG
   } dvs_type;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_MLO,
      ST_MHI,
      ST_MCHK,
      ST_FACT,
      ST_POW,
      ST_NPOW,
      ST_DIV,
      ST_REMTAKE,
      ST_SQRT,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic     load;
      logic     mul_lo;
      logic     mul_hi;
      logic     mag_from_prod;
      logic     cnt_inc;
      logic     cnt_dec;
      logic     div_init;
      logic     div_step;
      logic     rem_take;
      logic     sq_init;
      logic     sq_step;
      logic     fin_load;
      ysel_type y_sel;
      dvd_type  dvd_sel;
      dvs_type  dvs_sel;
      fin_type  fin;
   } cmd_type;

   typedef struct packed {
      logic mb_zero;
      logic a_neg;
      logic b_neg;
      logic ma_zero;
      logic ma_one;
      logic cnt_zero;
      logic fact_more;
      logic over;
      logic den_big;
   } sts_type;

endpackage

// ----- design/ica_dpath.sv -----
// Datapath: operand registers, shared multiplier, divider, square root and result register.
module ica_dpath #(
   parameter int OPERAND_WIDTH = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic                            clock,
   input  logic [ica_pkg::KIND_W-1:0]      kind,
   input  logic [31:0]                     first_operand,
   input  logic [31:0]                     second_operand,
   input  ica_pkg::cmd_type                cmd,
   output ica_pkg::sts_type                sts,
   output logic [ica_pkg::RESULT_W-1:0]    result_value,
   output logic [ica_pkg::STATUS_W-1:0]    status
);
   import ica_pkg::*;

   localparam int OW   = OPERAND_WIDTH;
   localparam int FB   = FRACTION_BITS;
   localparam int DIVW = OW + FB;
   localparam int DVSW = (OW > FB + 1) ? OW : FB + 1;
   localparam int SQW  = FB + 20;
   localparam logic [63:0] LIM_POS = 64'h7FFF_FFFF_FFFF_FFFF >> FB;
   localparam logic [63:0] LIM_NEG = 64'h8000_0000_0000_0000 >> FB;
   localparam logic [63:0] ONE     = 64'd1 << FB;

   logic [OW-1:0]   ma_ff, ma_in, mb_ff, mb_in, cnt_ff, cnt_in;
   logic            a_neg_ff, a_neg_in, b_neg_ff, b_neg_in, neg_ff, neg_in;
   logic [63:0]     mag_ff, mag_in, plo_ff, plo_in, res_ff, res_in;
   logic [95:0]     prod_ff, prod_in;
   logic [DIVW-1:0] dvd_ff, dvd_in;
   logic [DVSW-1:0] dvs_ff, dvs_in, r_ff, r_in;
   logic [SQW-1:0]  sq_rem_ff, sq_rem_in;
   logic [31:0]     sq_src_ff, sq_src_in;
   logic [1:0]      st_ff, st_in;

   logic signed [OW:0] a_x, b_x, sum_x, diff_x, ma_x, mb_x;
   logic [OW:0]     sum_abs, diff_abs;
   logic [31:0]     y32;
   logic [63:0]     p_lo, p_hi, sc_val;
   logic [DVSW:0]   r_sh, r_sub;
   logic [SQW-1:0]  s_sh, trial;
   logic [SQW:0]    s_sub;

   // extend operands and form sums and magnitudes
   always_comb begin
      a_x      = {first_operand[OW-1], first_operand[OW-1:0]};
      b_x      = {second_operand[OW-1], second_operand[OW-1:0]};
      sum_x    = a_x + b_x;
      diff_x   = a_x - b_x;
      sum_abs  = sum_x[OW] ? (OW+1)'(-sum_x) : (OW+1)'(sum_x);
      diff_abs = diff_x[OW] ? (OW+1)'(-diff_x) : (OW+1)'(diff_x);
      ma_x     = a_x[OW] ? -a_x : a_x;
      mb_x     = b_x[OW] ? -b_x : b_x;
   end

   // shared multiplier, divider and root step
   always_comb begin
      case (cmd.y_sel)
         Y_MB:    y32 = 32'(mb_ff);
         Y_MA:    y32 = 32'(ma_ff);
         Y_CNT:   y32 = 32'(cnt_ff);
         default: y32 = 32'(mb_ff);
      endcase
      p_lo  = 64'(mag_ff[31:0]) * 64'(y32);
      p_hi  = 64'(mag_ff[63:32]) * 64'(y32);
      r_sh  = {r_ff, dvd_ff[DIVW-1]};
      r_sub = r_sh - {1'b0, dvs_ff};
      s_sh  = {sq_rem_ff[SQW-3:0], sq_src_ff[31:30]};
      trial = {mag_ff[SQW-3:0], 2'b01};
      s_sub = {1'b0, s_sh} - {1'b0, trial};
   end

   // next values of the working registers
   always_comb begin
      ma_in     = ma_ff;
      mb_in     = mb_ff;
      a_neg_in  = a_neg_ff;
      b_neg_in  = b_neg_ff;
      neg_in    = neg_ff;
      mag_in    = mag_ff;
      cnt_in    = cnt_ff;
      plo_in    = plo_ff;
      prod_in   = prod_ff;
      dvd_in    = dvd_ff;
      dvs_in    = dvs_ff;
      r_in      = r_ff;
      sq_rem_in = sq_rem_ff;
      sq_src_in = sq_src_ff;
      res_in    = res_ff;
      st_in     = st_ff;
      sc_val    = mag_ff << FB;

      if (cmd.load) begin
         ma_in    = ma_x[OW-1:0];
         mb_in    = mb_x[OW-1:0];
         a_neg_in = a_x[OW];
         b_neg_in = b_x[OW];
         cnt_in   = mb_x[OW-1:0];
         mag_in   = 64'(ma_x[OW-1:0]);
         neg_in   = 1'b0;
         case (kind)
            K_ADD: begin
               neg_in = sum_x[OW];
               mag_in = 64'(sum_abs);
            end
            K_SUB: begin
               neg_in = diff_x[OW];
               mag_in = 64'(diff_abs);
            end
            K_MUL: begin
               neg_in = (a_x[OW] ^ b_x[OW]) && (ma_x != '0) && (mb_x != '0);
            end
            K_RDIV, K_IDIV: begin
               neg_in = a_x[OW] ^ b_x[OW];
            end
            K_REM: begin
               neg_in = a_x[OW];
            end
            K_FACT: begin
               mag_in = 64'd1;
               cnt_in = OW'(2);
            end
            K_POW: begin
               neg_in = a_x[OW] && b_x[0];
               mag_in = 64'd1;
            end
            default: begin
               neg_in = 1'b0;
            end
         endcase
      end

      // multiply in two halves, then accept the product
      if (cmd.mul_lo) plo_in = p_lo;
      if (cmd.mul_hi) prod_in = {p_hi, 32'b0} + 96'(plo_ff);
      if (cmd.mag_from_prod) mag_in = prod_ff[63:0];
      if (cmd.cnt_inc) cnt_in = cnt_ff + OW'(1);
      if (cmd.cnt_dec) cnt_in = cnt_ff - OW'(1);

      // restoring divider, one quotient bit per step
      if (cmd.div_init) begin
         case (cmd.dvd_sel)
            DVD_MA:        dvd_in = DIVW'(ma_ff);
            DVD_MA_SCALED: dvd_in = DIVW'(ma_ff) << FB;
            DVD_ONE:       dvd_in = DIVW'(ONE);
            default:       dvd_in = DIVW'(ma_ff);
         endcase
         dvs_in = (cmd.dvs_sel == DVS_MAG) ? mag_ff[DVSW-1:0] : DVSW'(mb_ff);
         r_in   = '0;
         mag_in = '0;
      end
      if (cmd.div_step) begin
         dvd_in = dvd_ff << 1;
         r_in   = r_sub[DVSW] ? r_sh[DVSW-1:0] : r_sub[DVSW-1:0];
         mag_in = {mag_ff[62:0], ~r_sub[DVSW]};
      end
      if (cmd.rem_take) mag_in = 64'(r_ff);

      // square root, one root bit per step, root held in mag
      if (cmd.sq_init) begin
         sq_rem_in = '0;
         sq_src_in = 32'(ma_ff);
         mag_in    = '0;
      end
      if (cmd.sq_step) begin
         sq_src_in = sq_src_ff << 2;
         sq_rem_in = s_sub[SQW] ? s_sh : s_sub[SQW-1:0];
         mag_in    = {mag_ff[62:0], ~s_sub[SQW]};
      end

      // form the final result
      if (cmd.fin_load) begin
         res_in = '0;
         st_in  = STS_OK;
         case (cmd.fin)
            FIN_INT:    res_in = neg_ff ? -sc_val : sc_val;
            FIN_SCALED: res_in = neg_ff ? -mag_ff : mag_ff;
            FIN_SAT: begin
               res_in = neg_ff ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
               st_in  = STS_SATURATED;
            end
            FIN_DIV0:   st_in = STS_DIV_ZERO;
            FIN_NEG:    st_in = STS_NEG_OPND;
            default:    res_in = '0;
         endcase
      end
   end

   // hold working registers
   always_ff @(posedge clock) begin
      ma_ff     <= ma_in;
      mb_ff     <= mb_in;
      a_neg_ff  <= a_neg_in;
      b_neg_ff  <= b_neg_in;
      neg_ff    <= neg_in;
      mag_ff    <= mag_in;
      cnt_ff    <= cnt_in;
      plo_ff    <= plo_in;
      prod_ff   <= prod_in;
      dvd_ff    <= dvd_in;
      dvs_ff    <= dvs_in;
      r_ff      <= r_in;
      sq_rem_ff <= sq_rem_in;
      sq_src_ff <= sq_src_in;
      res_ff    <= res_in;
      st_ff     <= st_in;
   end

   // status toward the controller
   always_comb begin
      sts.mb_zero   = (mb_ff == '0);
      sts.a_neg     = a_neg_ff;
      sts.b_neg     = b_neg_ff;
      sts.ma_zero   = (ma_ff == '0);
      sts.ma_one    = (ma_ff == OW'(1));
      sts.cnt_zero  = (cnt_ff == '0);
      sts.fact_more = (cnt_ff <= ma_ff);
      sts.over      = prod_ff > 96'(neg_ff ? LIM_NEG : LIM_POS);
      sts.den_big   = mag_ff > ONE;
   end

   assign result_value = res_ff;
   assign status       = st_ff;

endmodule

// ----- design/ica_ctrl.sv -----
// Controller: sequences each operation and owns the handshakes.
module ica_ctrl #(
   parameter int OPERAND_WIDTH = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [ica_pkg::KIND_W-1:0] kind,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  ica_pkg::sts_type           sts,
   output ica_pkg::cmd_type           cmd
);
   import ica_pkg::*;

   localparam int DIV_STEPS  = OPERAND_WIDTH + FRACTION_BITS;
   localparam int SQRT_STEPS = 16 + FRACTION_BITS;
   localparam int MAX_STEPS  = (DIV_STEPS > SQRT_STEPS) ? DIV_STEPS : SQRT_STEPS;
   localparam int ITW        = $clog2(MAX_STEPS + 1);

   state_type         state_ff, state_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [ITW-1:0]    iter_ff, iter_in;
   fin_type           fin_ff, fin_in;
   logic              vld_ff, vld_in;

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
      end
      kind_ff <= kind_in;
      iter_ff <= iter_in;
      fin_ff  <= fin_in;
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      kind_in    = kind_ff;
      iter_in    = iter_ff;
      fin_in     = fin_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.fin    = fin_ff;

      case (kind_type'(kind_ff))
         K_FACT:  cmd.y_sel = Y_CNT;
         K_POW:   cmd.y_sel = Y_MA;
         default: cmd.y_sel = Y_MB;
      endcase

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               kind_in  = kind;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            iter_in  = '0;
            fin_in   = FIN_ZERO;
            state_in = ST_FIN;
            case (kind_type'(kind_ff))
               K_ADD, K_SUB: fin_in = FIN_INT;
               K_MUL:        state_in = ST_MLO;
               K_RDIV, K_IDIV, K_REM: begin
                  if (sts.mb_zero) begin
                     fin_in = FIN_DIV0;
                  end else begin
                     cmd.div_init = 1'b1;
                     cmd.dvd_sel  = (kind_type'(kind_ff) == K_RDIV) ? DVD_MA_SCALED : DVD_MA;
                     cmd.dvs_sel  = DVS_MB;
                     state_in     = ST_DIV;
                  end
               end
               K_FACT: begin
                  if (sts.a_neg) fin_in = FIN_NEG;
                  else state_in = ST_FACT;
               end
               K_POW: begin
                  if (sts.b_neg) begin
                     if (sts.ma_zero) begin
                        fin_in = FIN_DIV0;
                     end else if (sts.ma_one) begin
                        cmd.div_init = 1'b1;
                        cmd.dvd_sel  = DVD_ONE;
                        cmd.dvs_sel  = DVS_MAG;
                        state_in     = ST_DIV;
                     end else begin
                        state_in = ST_NPOW;
                     end
                  end else if (sts.ma_zero) begin
                     fin_in = sts.cnt_zero ? FIN_INT : FIN_ZERO;
                  end else if (sts.ma_one) begin
                     fin_in = FIN_INT;
                  end else begin
                     state_in = ST_POW;
                  end
               end
               K_SQRT: begin
                  if (sts.a_neg) begin
                     fin_in = FIN_NEG;
                  end else begin
                     cmd.sq_init = 1'b1;
                     state_in    = ST_SQRT;
                  end
               end
               default: fin_in = FIN_ZERO;
            endcase
         end
         ST_MLO: begin
            cmd.mul_lo = 1'b1;
            state_in   = ST_MHI;
         end
         ST_MHI: begin
            cmd.mul_hi = 1'b1;
            state_in   = ST_MCHK;
         end
         ST_MCHK: begin
            // reciprocal power accumulates its denominator unchecked
            if (sts.over && !(kind_type'(kind_ff) == K_POW && sts.b_neg)) begin
               fin_in   = FIN_SAT;
               state_in = ST_FIN;
            end else begin
               cmd.mag_from_prod = 1'b1;
               case (kind_type'(kind_ff))
                  K_FACT: begin
                     cmd.cnt_inc = 1'b1;
                     state_in    = ST_FACT;
                  end
                  K_POW: begin
                     cmd.cnt_dec = 1'b1;
                     state_in    = sts.b_neg ? ST_NPOW : ST_POW;
                  end
                  default: begin
                     fin_in   = FIN_INT;
                     state_in = ST_FIN;
                  end
               endcase
            end
         end
         ST_FACT: begin
            if (sts.fact_more) begin
               state_in = ST_MLO;
            end else begin
               fin_in   = FIN_INT;
               state_in = ST_FIN;
            end
         end
         ST_POW: begin
            if (sts.cnt_zero) begin
               fin_in   = FIN_INT;
               state_in = ST_FIN;
            end else begin
               state_in = ST_MLO;
            end
         end
         ST_NPOW: begin
            if (sts.den_big) begin
               fin_in   = FIN_ZERO;
               state_in = ST_FIN;
            end else if (sts.cnt_zero) begin
               cmd.div_init = 1'b1;
               cmd.dvd_sel  = DVD_ONE;
               cmd.dvs_sel  = DVS_MAG;
               iter_in      = '0;
               state_in     = ST_DIV;
            end else begin
               state_in = ST_MLO;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            iter_in      = iter_ff + ITW'(1);
            if (iter_ff == ITW'(DIV_STEPS - 1)) begin
               case (kind_type'(kind_ff))
                  K_REM: begin
                     fin_in   = FIN_INT;
                     state_in = ST_REMTAKE;
                  end
                  K_IDIV: begin
                     fin_in   = FIN_INT;
                     state_in = ST_FIN;
                  end
                  default: begin
                     fin_in   = FIN_SCALED;
                     state_in = ST_FIN;
                  end
               endcase
            end
         end
         ST_REMTAKE: begin
            cmd.rem_take = 1'b1;
            state_in     = ST_FIN;
         end
         ST_SQRT: begin
            cmd.sq_step = 1'b1;
            iter_in     = iter_ff + ITW'(1);
            if (iter_ff == ITW'(SQRT_STEPS - 1)) begin
               fin_in   = FIN_SCALED;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // advance once the output register is free
            if (!vld_ff || rsp_tready) begin
               cmd.fin_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // output item valid
      if (cmd.fin_load) vld_in = 1'b1;
      else if (rsp_tready) vld_in = 1'b0;
      else vld_in = vld_ff;
   end

   assign rsp_tvalid = vld_ff;

endmodule

// ----- design/integer_calculator_alu_core.sv -----
// Integer calculator ALU top level: controller and datapath.
// Add, sub and errors go from decode to the result; mul runs both halves and a range check;
// divide one quotient bit a cycle (remainder adds a take state); sqrt one root bit a cycle.
// Power repeats both halves, range check and exponent step, factorial likewise per factor, on the
// shared 64x32 multiply in 32-bit halves, stopping early once out of range (under 64 steps).
// One item at a time; the next is taken while a result waits. Synchronous reset clears control.
module integer_calculator_alu_core #(
   parameter int OPERAND_WIDTH = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // first_operand[31:0], second_operand[63:32]
   input  logic [3:0]  req_tuser,   // kind[3:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // result_value[63:0]
   output logic [1:0]  rsp_tuser    // status[1:0]
);
   import ica_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencing
   ica_ctrl #(
      .OPERAND_WIDTH(OPERAND_WIDTH),
      .FRACTION_BITS(FRACTION_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .kind       (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // arithmetic
   ica_dpath #(
      .OPERAND_WIDTH(OPERAND_WIDTH),
      .FRACTION_BITS(FRACTION_BITS)
   ) u_dpath (
      .clock          (clock),
      .kind           (req_tuser),
      .first_operand  (req_tdata[31:0]),
      .second_operand (req_tdata[63:32]),
      .cmd            (cmd),
      .sts            (sts),
      .result_value   (rsp_tdata),
      .status         (rsp_tuser)
   );

endmodule
